// ===== src/png_csp_pkg.sv =====
// Shared constants, codes and the CRC-32 byte update for the PNG chunk stream parser.
`timescale 1ns / 1ps
`default_nettype none

package png_csp_pkg;

   // Widths of the transaction fields.
   localparam int unsigned ByteWidth   = 8;
   localparam int unsigned KindWidth   = 3;
   localparam int unsigned StatusWidth = 4;
   localparam int unsigned LimitWidth  = 9;
   localparam int unsigned CountWidth  = 9;

   // Default upper bound on accepted iTXt chunks, and the limit register reset value.
   localparam int unsigned MaxTextChunksDefault = 256;
   localparam logic [LimitWidth-1:0] TextLimitReset = 9'd256;

   // Chunk kinds.
   localparam logic [KindWidth-1:0] KIND_IHDR  = 3'd0;
   localparam logic [KindWidth-1:0] KIND_PLTE  = 3'd1;
   localparam logic [KindWidth-1:0] KIND_IDAT  = 3'd2;
   localparam logic [KindWidth-1:0] KIND_IEND  = 3'd3;
   localparam logic [KindWidth-1:0] KIND_ITXT  = 3'd4;
   localparam logic [KindWidth-1:0] KIND_OTHER = 3'd5;

   // Parse status codes.
   localparam logic [StatusWidth-1:0] ST_BUSY       = 4'd0;
   localparam logic [StatusWidth-1:0] ST_CHUNK_OK   = 4'd1;
   localparam logic [StatusWidth-1:0] ST_IEND_DONE  = 4'd2;
   localparam logic [StatusWidth-1:0] ST_BAD_SIG    = 4'd3;
   localparam logic [StatusWidth-1:0] ST_CRC_ERR    = 4'd4;
   localparam logic [StatusWidth-1:0] ST_DUP_IHDR   = 4'd5;
   localparam logic [StatusWidth-1:0] ST_TEXT_EARLY = 4'd6;
   localparam logic [StatusWidth-1:0] ST_TEXT_LIMIT = 4'd7;
   localparam logic [StatusWidth-1:0] ST_NO_IEND    = 4'd8;
   localparam logic [StatusWidth-1:0] ST_IHDR_SHORT = 4'd9;

   // Chunk type words, big-endian ASCII.
   localparam logic [31:0] TYPE_IHDR = 32'h4948_4452;
   localparam logic [31:0] TYPE_PLTE = 32'h504C_5445;
   localparam logic [31:0] TYPE_IDAT = 32'h4944_4154;
   localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;
   localparam logic [31:0] TYPE_ITXT = 32'h6954_5874;

   localparam logic [31:0] CrcPreset = 32'hFFFF_FFFF;
   localparam logic [31:0] CrcPoly   = 32'hEDB8_8320;

   // Minimum IHDR payload length.
   localparam logic [31:0] IhdrLength = 32'd13;

   // The eight-byte file signature, indexed by byte position.
   function automatic logic [ByteWidth-1:0] sig_byte(input logic [2:0] idx);
      logic [ByteWidth-1:0] val;
      unique case (idx)
         3'd0: val = 8'h89;
         3'd1: val = 8'h50;
         3'd2: val = 8'h4E;
         3'd3: val = 8'h47;
         3'd4: val = 8'h0D;
         3'd5: val = 8'h0A;
         3'd6: val = 8'h1A;
         3'd7: val = 8'h0A;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

   // Reflected CRC-32 update by one byte.
   function automatic logic [31:0] crc32_byte(input logic [31:0] crc,
                                              input logic [ByteWidth-1:0] data);
      logic [31:0] acc;
      acc = crc ^ {24'h0, data};
      for (int i = 0; i < 8; i++) begin
         acc = acc[0] ? ((acc >> 1) ^ CrcPoly) : (acc >> 1);
      end
      return acc;
   endfunction

   function automatic logic [KindWidth-1:0] decode_kind(input logic [31:0] tword);
      logic [KindWidth-1:0] k;
      priority if (tword == TYPE_IHDR) k = KIND_IHDR;
      else if (tword == TYPE_PLTE) k = KIND_PLTE;
      else if (tword == TYPE_IDAT) k = KIND_IDAT;
      else if (tword == TYPE_IEND) k = KIND_IEND;
      else if (tword == TYPE_ITXT) k = KIND_ITXT;
      else k = KIND_OTHER;
      return k;
   endfunction

endpackage

`default_nettype wire

// ===== src/png_chunk_stream_parser_unit.sv =====
// PNG chunk stream parser: signature check, chunk deframing, CRC-32 check and IHDR capture.
`timescale 1ns / 1ps
`default_nettype none
// A result transaction is registered and appears in the cycle after its input byte is accepted.
// Throughput: one byte per cycle while results are taken; the byte-wide CRC-32 update and the field counter
// compare sit between the parse state registers and the result register.
// The block takes a new byte while a result waits as long as the result is taken in that cycle.
// Reset (synchronous, active high) clears the parse state and sets the iTXt limit to 256.

module png_chunk_stream_parser_unit
   import png_csp_pkg::*;
#(
   parameter int unsigned MAX_TEXT_CHUNKS = MaxTextChunksDefault
) (
   input  wire logic                   clock,
   input  wire logic                   reset,

   // Input byte stream.
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [7:0]             req_tdata,   // [7:0] in_byte
   input  wire logic                   req_tuser,   // [0] start_of_file
   input  wire logic                   req_tlast,   // end_of_stream

   // Result stream.
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // [7:0] payload_byte, [10:8] chunk_kind, [14:11] parse_status, [15] header_valid,
   // [47:16] image_width, [79:48] image_height, [87:80] bit_depth, [95:88] colour_type,
   // [103:96] compression_method, [111:104] filter_method, [119:112] interlace_method
   output logic [119:0]                rsp_tdata,
   output logic                        rsp_tuser,   // [0] payload_valid

   // iTXt chunk limit register.
   input  wire logic                   csr_we,
   input  wire logic [LimitWidth-1:0]  csr_wdata
);

   typedef enum logic [2:0] {
      PH_SIG,
      PH_LEN,
      PH_TYPE,
      PH_DATA,
      PH_CRC
   } phase_type;

   localparam int unsigned CmpWidth = 17;
   localparam logic [CmpWidth-1:0] MaxText = CmpWidth'(MAX_TEXT_CHUNKS);

   // Parse state.
   phase_type                 phase_ff, phase_in;
   logic [31:0]               cnt_ff, cnt_in;
   logic [31:0]               dlen_ff, dlen_in;
   logic [31:0]               tword_ff, tword_in;
   logic [31:0]               crc_ff, crc_in;
   logic [31:0]               rcrc_ff, rcrc_in;
   logic [63:0]               shadow_ff, shadow_in;
   logic [39:0]               shadow_bytes_ff, shadow_bytes_in;
   logic                      hdr_seen_ff, hdr_seen_in;
   logic [CountWidth-1:0]     text_cnt_ff, text_cnt_in;
   logic                      halted_ff, halted_in;
   logic [StatusWidth-1:0]    final_ff, final_in;
   logic [KindWidth-1:0]      kind_ff, kind_in;
   logic [63:0]               dims_ff, dims_in;
   logic [39:0]               hbytes_ff, hbytes_in;
   logic [LimitWidth-1:0]     limit_ff;

   // Result register.
   logic                      out_valid_ff;
   logic                      pv_ff, pv_in;
   logic [ByteWidth-1:0]      pb_ff, pb_in;
   logic [StatusWidth-1:0]    status_ff, status_in;

   logic                      accept;
   logic [ByteWidth-1:0]      in_byte;
   logic [CmpWidth-1:0]       limit_eff;
   logic [31:0]               cnt_inc;

   assign in_byte    = req_tdata;
   assign req_tready = !out_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   // The iTXt limit in force is the smaller of the register and the build-time bound.
   assign limit_eff = ({8'h0, limit_ff} < MaxText) ? {8'h0, limit_ff} : MaxText;

   always_comb begin
      phase_in        = phase_ff;
      cnt_in          = cnt_ff;
      dlen_in         = dlen_ff;
      tword_in        = tword_ff;
      crc_in          = crc_ff;
      rcrc_in         = rcrc_ff;
      shadow_in       = shadow_ff;
      shadow_bytes_in = shadow_bytes_ff;
      hdr_seen_in     = hdr_seen_ff;
      text_cnt_in     = text_cnt_ff;
      halted_in       = halted_ff;
      final_in        = final_ff;
      kind_in         = kind_ff;
      dims_in         = dims_ff;
      hbytes_in       = hbytes_ff;
      pv_in           = 1'b0;
      pb_in           = '0;
      status_in       = ST_BUSY;

      // A start-of-file byte restarts the parse before it is itself examined.
      if (req_tuser) begin
         phase_in        = PH_SIG;
         cnt_in          = '0;
         dlen_in         = '0;
         tword_in        = '0;
         crc_in          = CrcPreset;
         rcrc_in         = '0;
         shadow_in       = '0;
         shadow_bytes_in = '0;
         hdr_seen_in     = 1'b0;
         text_cnt_in     = '0;
         halted_in       = 1'b0;
         final_in        = ST_BUSY;
         kind_in         = KIND_OTHER;
         dims_in         = '0;
         hbytes_in       = '0;
      end

      cnt_inc = cnt_in + 32'd1;

      if (halted_in) begin
         status_in = final_in;
      end else begin
         unique case (phase_in)
            PH_SIG: begin
               if (in_byte != sig_byte(cnt_in[2:0])) begin
                  halted_in = 1'b1;
                  final_in  = ST_BAD_SIG;
                  status_in = ST_BAD_SIG;
               end else if (cnt_in[2:0] == 3'd7) begin
                  phase_in = PH_LEN;
                  cnt_in   = '0;
               end else begin
                  cnt_in = cnt_inc;
               end
            end
            PH_LEN: begin
               dlen_in = {dlen_in[23:0], in_byte};
               if (cnt_in[1:0] == 2'd3) begin
                  phase_in = PH_TYPE;
                  cnt_in   = '0;
                  crc_in   = CrcPreset;
                  tword_in = '0;
               end else begin
                  cnt_in = cnt_inc;
               end
            end
            PH_TYPE: begin
               tword_in = {tword_in[23:0], in_byte};
               crc_in   = crc32_byte(crc_in, in_byte);
               if (cnt_in[1:0] == 2'd3) begin
                  kind_in         = decode_kind(tword_in);
                  cnt_in          = '0;
                  shadow_in       = '0;
                  shadow_bytes_in = '0;
                  rcrc_in         = '0;
                  phase_in        = (dlen_in == 32'd0) ? PH_CRC : PH_DATA;
               end else begin
                  cnt_in = cnt_inc;
               end
            end
            PH_DATA: begin
               pv_in  = 1'b1;
               pb_in  = in_byte;
               crc_in = crc32_byte(crc_in, in_byte);
               // IHDR: width and height go to the shadow, then the five single-byte fields.
               if (kind_in == KIND_IHDR) begin
                  if (cnt_in < 32'd8) begin
                     shadow_in = {shadow_in[55:0], in_byte};
                  end else if (cnt_in < IhdrLength) begin
                     shadow_bytes_in = {shadow_bytes_in[31:0], in_byte};
                  end
               end
               if (cnt_inc >= dlen_in) begin
                  phase_in = PH_CRC;
                  cnt_in   = '0;
                  rcrc_in  = '0;
               end else begin
                  cnt_in = cnt_inc;
               end
            end
            PH_CRC: begin
               rcrc_in = {rcrc_in[23:0], in_byte};
               if (cnt_in[1:0] == 2'd3) begin
                  // Chunk end checks, in order of precedence.
                  priority if (~crc_in != rcrc_in) begin
                     halted_in = 1'b1;
                     final_in  = ST_CRC_ERR;
                     status_in = ST_CRC_ERR;
                  end else if (kind_in == KIND_IHDR && hdr_seen_in) begin
                     halted_in = 1'b1;
                     final_in  = ST_DUP_IHDR;
                     status_in = ST_DUP_IHDR;
                  end else if (kind_in == KIND_IHDR && dlen_in < IhdrLength) begin
                     halted_in = 1'b1;
                     final_in  = ST_IHDR_SHORT;
                     status_in = ST_IHDR_SHORT;
                  end else if (kind_in == KIND_IHDR) begin
                     dims_in     = shadow_in;
                     hbytes_in   = shadow_bytes_in;
                     hdr_seen_in = 1'b1;
                     status_in   = ST_CHUNK_OK;
                  end else if (kind_in == KIND_ITXT && !hdr_seen_in) begin
                     halted_in = 1'b1;
                     final_in  = ST_TEXT_EARLY;
                     status_in = ST_TEXT_EARLY;
                  end else if (kind_in == KIND_ITXT
                               && {8'h0, text_cnt_in} >= limit_eff) begin
                     halted_in = 1'b1;
                     final_in  = ST_TEXT_LIMIT;
                     status_in = ST_TEXT_LIMIT;
                  end else if (kind_in == KIND_ITXT) begin
                     text_cnt_in = text_cnt_in + CountWidth'(1);
                     status_in   = ST_CHUNK_OK;
                  end else if (kind_in == KIND_IEND) begin
                     halted_in = 1'b1;
                     final_in  = ST_IEND_DONE;
                     status_in = ST_IEND_DONE;
                  end else begin
                     status_in = ST_CHUNK_OK;
                  end
                  cnt_in  = '0;
                  dlen_in = '0;
                  if (!halted_in) begin
                     phase_in = PH_LEN;
                  end
               end else begin
                  cnt_in = cnt_inc;
               end
            end
            default: begin
               phase_in = PH_SIG;
            end
         endcase

         // The source has run dry without a clean end of file.
         if (req_tlast && !halted_in) begin
            status_in = (phase_in == PH_SIG) ? ST_BAD_SIG : ST_NO_IEND;
            halted_in = 1'b1;
            final_in  = status_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_SIG;
         cnt_ff          <= '0;
         dlen_ff         <= '0;
         tword_ff        <= '0;
         crc_ff          <= CrcPreset;
         rcrc_ff         <= '0;
         shadow_ff       <= '0;
         shadow_bytes_ff <= '0;
         hdr_seen_ff     <= 1'b0;
         text_cnt_ff     <= '0;
         halted_ff       <= 1'b0;
         final_ff        <= ST_BUSY;
         kind_ff         <= KIND_OTHER;
         dims_ff         <= '0;
         hbytes_ff       <= '0;
         limit_ff        <= TextLimitReset;
         out_valid_ff    <= 1'b0;
      end else begin
         if (csr_we) begin
            limit_ff <= csr_wdata;
         end
         if (accept) begin
            phase_ff        <= phase_in;
            cnt_ff          <= cnt_in;
            dlen_ff         <= dlen_in;
            tword_ff        <= tword_in;
            crc_ff          <= crc_in;
            rcrc_ff         <= rcrc_in;
            shadow_ff       <= shadow_in;
            shadow_bytes_ff <= shadow_bytes_in;
            hdr_seen_ff     <= hdr_seen_in;
            text_cnt_ff     <= text_cnt_in;
            halted_ff       <= halted_in;
            final_ff        <= final_in;
            kind_ff         <= kind_in;
            dims_ff         <= dims_in;
            hbytes_ff       <= hbytes_in;
            out_valid_ff    <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Payload part of the result register; no reset needed.
   always_ff @(posedge clock) begin
      if (accept) begin
         pv_ff     <= pv_in;
         pb_ff     <= pb_in;
         status_ff <= status_in;
      end
   end

   // The kind and the committed header only change on an accepted byte, which also
   // reloads the result register, so they are read straight from the parse state.
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = pv_ff;
   assign rsp_tdata  = {hbytes_ff[7:0], hbytes_ff[15:8], hbytes_ff[23:16],
                        hbytes_ff[31:24], hbytes_ff[39:32],
                        dims_ff[31:0], dims_ff[63:32],
                        hdr_seen_ff, status_ff, kind_ff, pb_ff};

endmodule

`default_nettype wire
